@@ rtl/firq16_pkg.sv @@
// Shared types and constants of the 32-tap Q16.16 FIR filter.
`default_nettype none

package firq16_pkg;

   localparam int unsigned TAPS      = 32;
   localparam int unsigned FRAC_BITS = 16;
   localparam int unsigned DATA_W    = 32;
   localparam int unsigned TIDX_W    = 5;
   localparam int unsigned PROD_W    = 2 * DATA_W;
   localparam int unsigned TAP_W     = $clog2(TAPS);
   localparam int unsigned FILL_W    = $clog2(TAPS + 1);
   localparam int unsigned ACC_W     = PROD_W + $clog2(TAPS);

   typedef enum logic {
      CMD_PUSH = 1'b0,
      CMD_COEF = 1'b1
   } cmd_type;

   typedef logic signed [DATA_W-1:0] sample_type;

endpackage

`default_nettype wire

@@ rtl/firq16_if.sv @@
// Request and response channel interfaces of the FIR filter.
`default_nettype none

interface firq16_req_if;
   import firq16_pkg::*;

   logic                    valid;
   logic                    ready;
   cmd_type                 cmd;
   sample_type              value;
   logic [TIDX_W-1:0]       tap_index;

   modport source (output valid, output cmd, output value, output tap_index, input ready);
   modport sink (input valid, input cmd, input value, input tap_index, output ready);
endinterface

interface firq16_rsp_if;
   import firq16_pkg::*;

   logic       valid;
   logic       ready;
   sample_type filtered;
   logic       saturated;

   modport source (output valid, output filtered, output saturated, input ready);
   modport sink (input valid, input filtered, input saturated, output ready);
endinterface

`default_nettype wire

@@ rtl/fir_filter_q16_unit.sv @@
// Top level of the 32-tap direct-form FIR filter on Q16.16 samples.
//
// Requests arrive on req_chan. A request with cmd set to the coefficient code
// loads one tap coefficient and produces no response; an index beyond the
// last tap is ignored. A request with cmd set to the push code shifts the
// sample into the delay line and produces one response on rsp_chan holding
// the shifted, saturated sum of products and a flag that tells whether it
// was clamped.
// Samples live in a circular buffer memory and coefficients in a second
// memory, both read through registers. One shared multiplier and a wide
// accumulator step through one tap per cycle: the memories are read, the
// product is registered and then added into the accumulator, and after the
// last tap the wait and finish states load the response register.
// A new request is accepted only while no sample is being filtered, so a
// sample is not taken before the last one has its response loaded, while
// coefficient loads can follow every cycle while idle. The response register
// lets the next request in while a response waits.
// If the receiver stalls, a finished sum is held until the response register
// frees up. Reset empties the delay line and clears every coefficient
// through fill and valid flags, so no clearing pass is needed.
`default_nettype none

module fir_filter_q16_unit (
   input  wire                   clock,
   input  wire                   reset,
   firq16_req_if.sink            req_chan,
   firq16_rsp_if.source          rsp_chan
);
   import firq16_pkg::*;

   typedef enum logic [1:0] {
      S_IDLE,
      S_RUN,
      S_WAIT,
      S_FINISH
   } state_type;

   state_type               state_ff, state_in;
   logic [TAP_W-1:0]        head_ff, head_in;
   logic [TAP_W-1:0]        dptr_ff, dptr_in;
   logic [TAP_W-1:0]        k_ff, k_in;
   logic [FILL_W-1:0]       fill_ff, fill_in;
   logic [TAPS-1:0]         cvld_ff, cvld_in;
   logic                    rd_vld_ff, rd_last_ff, dl_ok_ff, cf_ok_ff;
   logic                    prod_vld_ff, prod_last_ff;
   logic                    done_ff, done_in;
   logic                    rsp_vld_ff, rsp_vld_in;
   sample_type              rsp_filt_ff;
   logic                    rsp_sat_ff;

   logic [DATA_W-1:0]       dl_mem [TAPS];
   logic [DATA_W-1:0]       cf_mem [TAPS];
   logic [DATA_W-1:0]       dl_rd_ff, cf_rd_ff;
   logic signed [PROD_W-1:0] prod_ff;
   logic signed [ACC_W-1:0]  acc_ff;

   logic                    accept, push, coef_wr, issue, last_issue, load_rsp;
   logic [TAP_W-1:0]        coef_addr;
   sample_type              op_a, op_b;
   logic signed [ACC_W-1:0] acc_sh;
   logic                    in_range;
   sample_type              filt_in;

   assign accept     = req_chan.valid && req_chan.ready;
   assign push       = accept && (req_chan.cmd == CMD_PUSH);
   assign coef_wr    = accept && (req_chan.cmd == CMD_COEF)
                       && (32'(req_chan.tap_index) < TAPS);
   assign coef_addr  = TAP_W'(req_chan.tap_index);
   assign issue      = (state_ff == S_RUN);
   assign last_issue = (k_ff == TAP_W'(TAPS - 1));
   assign load_rsp   = (state_ff == S_FINISH) && (!rsp_vld_ff || rsp_chan.ready);

   assign req_chan.ready     = (state_ff == S_IDLE);
   assign rsp_chan.valid     = rsp_vld_ff;
   assign rsp_chan.filtered  = rsp_filt_ff;
   assign rsp_chan.saturated = rsp_sat_ff;

   // Sample and coefficient memories.
   always_ff @(posedge clock) begin
      if (push) begin
         dl_mem[head_in] <= req_chan.value;
      end
      dl_rd_ff <= dl_mem[dptr_ff];
   end

   always_ff @(posedge clock) begin
      if (coef_wr) begin
         cf_mem[coef_addr] <= req_chan.value;
      end
      cf_rd_ff <= cf_mem[k_ff];
   end

   assign op_a = dl_ok_ff ? sample_type'(dl_rd_ff) : '0;
   assign op_b = cf_ok_ff ? sample_type'(cf_rd_ff) : '0;

   assign acc_sh   = acc_ff >>> FRAC_BITS;
   assign in_range = (&acc_sh[ACC_W-1:DATA_W-1]) || !(|acc_sh[ACC_W-1:DATA_W-1]);
   assign filt_in  = in_range ? sample_type'(acc_sh[DATA_W-1:0])
                   : (acc_sh[ACC_W-1] ? sample_type'({1'b1, {(DATA_W-1){1'b0}}})
                                      : sample_type'({1'b0, {(DATA_W-1){1'b1}}}));

   always_comb begin
      state_in   = state_ff;
      head_in    = head_ff;
      dptr_in    = dptr_ff;
      k_in       = k_ff;
      fill_in    = fill_ff;
      cvld_in    = cvld_ff;
      done_in    = done_ff;
      rsp_vld_in = rsp_vld_ff;
      if (rsp_vld_ff && rsp_chan.ready) begin
         rsp_vld_in = 1'b0;
      end
      if (coef_wr) begin
         cvld_in[coef_addr] = 1'b1;
      end
      case (state_ff)
         S_IDLE: begin
            if (push) begin
               head_in  = (head_ff == TAP_W'(TAPS - 1)) ? '0 : head_ff + 1'b1;
               dptr_in  = head_in;
               k_in     = '0;
               if (fill_ff != FILL_W'(TAPS)) begin
                  fill_in = fill_ff + 1'b1;
               end
               state_in = S_RUN;
            end
         end
         S_RUN: begin
            dptr_in = (dptr_ff == '0) ? TAP_W'(TAPS - 1) : dptr_ff - 1'b1;
            k_in    = k_ff + 1'b1;
            if (last_issue) begin
               state_in = S_WAIT;
            end
         end
         S_WAIT: begin
            if (done_ff) begin
               state_in = S_FINISH;
            end
         end
         S_FINISH: begin
            if (load_rsp) begin
               rsp_vld_in = 1'b1;
               done_in    = 1'b0;
               state_in   = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
      if (prod_vld_ff && prod_last_ff) begin
         done_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         head_ff      <= '0;
         dptr_ff      <= '0;
         k_ff         <= '0;
         fill_ff      <= '0;
         cvld_ff      <= '0;
         rd_vld_ff    <= 1'b0;
         rd_last_ff   <= 1'b0;
         prod_vld_ff  <= 1'b0;
         prod_last_ff <= 1'b0;
         done_ff      <= 1'b0;
         rsp_vld_ff   <= 1'b0;
      end else begin
         state_ff     <= state_in;
         head_ff      <= head_in;
         dptr_ff      <= dptr_in;
         k_ff         <= k_in;
         fill_ff      <= fill_in;
         cvld_ff      <= cvld_in;
         rd_vld_ff    <= issue;
         rd_last_ff   <= issue && last_issue;
         prod_vld_ff  <= rd_vld_ff;
         prod_last_ff <= rd_last_ff;
         done_ff      <= done_in;
         rsp_vld_ff   <= rsp_vld_in;
      end
   end

   // Datapath: operand masks, product, accumulator and response payload.
   always_ff @(posedge clock) begin
      dl_ok_ff <= (FILL_W'(k_ff) < fill_ff);
      cf_ok_ff <= cvld_ff[k_ff];
      prod_ff  <= op_a * op_b;
      if (push) begin
         acc_ff <= '0;
      end else if (prod_vld_ff) begin
         acc_ff <= acc_ff + ACC_W'(prod_ff);
      end
      if (load_rsp) begin
         rsp_filt_ff <= filt_in;
         rsp_sat_ff  <= !in_range;
      end
   end

`ifndef SYNTH
   a_pipe_busy: assert property (@(posedge clock) disable iff (reset)
      (rd_vld_ff || prod_vld_ff) |-> (state_ff == S_RUN || state_ff == S_WAIT))
      else $error("tap pipeline active outside a computation");

   a_push_starts: assert property (@(posedge clock) disable iff (reset)
      push |=> (state_ff == S_RUN && k_ff == '0))
      else $error("accepted sample did not start the tap loop at tap zero");

   a_fill_bound: assert property (@(posedge clock) disable iff (reset)
      fill_ff <= FILL_W'(TAPS))
      else $error("delay line fill count beyond the tap count");

   a_done_wait: assert property (@(posedge clock) disable iff (reset)
      done_ff |-> (state_ff == S_WAIT || state_ff == S_FINISH))
      else $error("sum finished outside the wait or finish state");

   a_sat_clamp: assert property (@(posedge clock) disable iff (reset)
      load_rsp |=> (!rsp_sat_ff
                    || rsp_filt_ff == sample_type'({1'b1, {(DATA_W-1){1'b0}}})
                    || rsp_filt_ff == sample_type'({1'b0, {(DATA_W-1){1'b1}}})))
      else $error("saturated response not clamped to a range limit");
`endif

endmodule

`default_nettype wire

@@ verif/fir_filter_q16_checker.sv @@
// Checker that predicts and compares every response of the Q16.16 FIR filter.
`timescale 1ns / 1ps

module fir_filter_q16_checker (
   input  wire         clock,
   input  wire         reset,
   firq16_req_if       req_mon,
   firq16_rsp_if       rsp_mon,
   output int unsigned error_count,
   output int unsigned pending_count,
   output int unsigned response_count,
   output int unsigned clamp_count
);
   import firq16_pkg::*;

   localparam int unsigned WIDE_W = 72;
   localparam int unsigned REPORT_MAX = 10;
   localparam logic signed [WIDE_W-1:0] OUT_MAX = 2147483647;
   localparam logic signed [WIDE_W-1:0] OUT_MIN = -OUT_MAX - 1;

   typedef struct packed {
      sample_type filtered;
      logic       saturated;
   } fir_output_type;

   sample_type     sample_hist [TAPS];
   sample_type     coef_bank [TAPS];
   fir_output_type filter_expect_q [$];
   int unsigned    fail_total = 0;
   int unsigned    seen_total = 0;
   int unsigned    clamp_total = 0;

   function automatic fir_output_type filter_sample(input sample_type sample);
      logic signed [WIDE_W-1:0] acc;
      logic signed [WIDE_W-1:0] scaled;
      logic signed [PROD_W-1:0] tap_val;
      logic signed [PROD_W-1:0] coef_val;
      logic signed [PROD_W-1:0] prod;
      fir_output_type           res;
      for (int k = TAPS - 1; k > 0; k--) begin
         sample_hist[k] = sample_hist[k-1];
      end
      sample_hist[0] = sample;
      acc = '0;
      for (int k = 0; k < TAPS; k++) begin
         tap_val  = sample_hist[k];
         coef_val = coef_bank[k];
         prod     = tap_val * coef_val;
         acc      = acc + prod;
      end
      scaled = acc >>> FRAC_BITS;
      if (scaled > OUT_MAX) begin
         res.filtered  = sample_type'(OUT_MAX);
         res.saturated = 1'b1;
      end else if (scaled < OUT_MIN) begin
         res.filtered  = sample_type'(OUT_MIN);
         res.saturated = 1'b1;
      end else begin
         res.filtered  = sample_type'(scaled);
         res.saturated = 1'b0;
      end
      return res;
   endfunction

   task automatic flag_failure(input string what);
      fail_total++;
      if (fail_total <= REPORT_MAX) begin
         $display("[%0t] mismatch: %s", $realtime, what);
      end
   endtask

   always @(posedge clock) begin
      fir_output_type want;
      if (reset) begin
         for (int k = 0; k < TAPS; k++) begin
            sample_hist[k] = '0;
            coef_bank[k]   = '0;
         end
         filter_expect_q.delete();
      end else begin
         if (rsp_mon.valid && rsp_mon.ready) begin
            seen_total++;
            if (rsp_mon.saturated) begin
               clamp_total++;
            end
            if (filter_expect_q.size() == 0) begin
               flag_failure($sformatf("response %0d/%0b arrived with none outstanding",
                                      rsp_mon.filtered, rsp_mon.saturated));
            end else begin
               want = filter_expect_q.pop_front();
               if (want.filtered !== rsp_mon.filtered ||
                   want.saturated !== rsp_mon.saturated) begin
                  flag_failure($sformatf("expected filtered %0d sat %0b, got %0d sat %0b",
                                         want.filtered, want.saturated,
                                         rsp_mon.filtered, rsp_mon.saturated));
               end
            end
         end
         if (req_mon.valid && req_mon.ready) begin
            if (req_mon.cmd == CMD_COEF) begin
               coef_bank[req_mon.tap_index] = req_mon.value;
            end else begin
               filter_expect_q.push_back(filter_sample(req_mon.value));
            end
         end
      end
      error_count    <= fail_total;
      pending_count  <= filter_expect_q.size();
      response_count <= seen_total;
      clamp_count    <= clamp_total;
   end

endmodule

@@ verif/tb_top.sv @@
// Top of the FIR filter testbench: clock, reset, request stimulus and verdict.
`timescale 1ns / 1ps

module tb_top;
   import firq16_pkg::*;

   localparam int unsigned RANDOM_ITEMS = 900;
   localparam int unsigned TAIL_CYCLES  = 60;
   localparam int unsigned CYCLE_LIMIT  = 400000;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   int unsigned cycle_count = 0;
   int unsigned sent_total = 0;
   int unsigned sample_total = 0;
   int unsigned coef_total = 0;
   int unsigned rsp_done = 0;
   bit          req_quiet = 1'b0;
   bit          rsp_quiet = 1'b0;
   int unsigned error_count;
   int unsigned pending_count;
   int unsigned response_count;
   int unsigned clamp_count;

   firq16_req_if req_bus ();
   firq16_rsp_if rsp_bus ();

   fir_filter_q16_unit u_dut (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_bus),
      .rsp_chan (rsp_bus)
   );

   fir_filter_q16_checker u_checker (
      .clock          (clock),
      .reset          (reset),
      .req_mon        (req_bus),
      .rsp_mon        (rsp_bus),
      .error_count    (error_count),
      .pending_count  (pending_count),
      .response_count (response_count),
      .clamp_count    (clamp_count)
   );

   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("TB_ERROR");
         $finish;
      end
   end

   function automatic sample_type pick_value();
      int unsigned sel;
      sel = $urandom_range(0, 15);
      if (sel == 0) return 32'h7fff_ffff;
      if (sel == 1) return 32'h8000_0000;
      if (sel == 2) return 32'hffff_ffff;
      if (sel <= 4) return $urandom;
      return sample_type'(int'($urandom_range(0, 524288)) - 262144);
   endfunction

   task automatic send_request(input cmd_type op, input sample_type val,
                               input logic [TIDX_W-1:0] idx);
      int unsigned gap;
      if (sent_total % 50 == 0) begin
         req_quiet = ($urandom_range(0, 3) == 0);
      end
      gap = req_quiet ? 0 : $urandom_range(0, 4);
      if (gap > 0) begin
         req_bus.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_bus.valid     <= 1'b1;
      req_bus.cmd       <= op;
      req_bus.value     <= val;
      req_bus.tap_index <= idx;
      do @(posedge clock); while (!req_bus.ready);
      sent_total++;
      if (op == CMD_PUSH) begin
         sample_total++;
      end else begin
         coef_total++;
      end
   endtask

   initial begin
      int unsigned stall;
      rsp_bus.ready <= 1'b0;
      do @(posedge clock); while (reset);
      forever begin
         if (rsp_done % 40 == 0) begin
            rsp_quiet = ($urandom_range(0, 3) == 0);
         end
         stall = rsp_quiet ? 0 : $urandom_range(0, 4);
         if (stall > 0) begin
            rsp_bus.ready <= 1'b0;
            repeat (stall) @(posedge clock);
         end
         rsp_bus.ready <= 1'b1;
         do @(posedge clock); while (!(rsp_bus.valid && rsp_bus.ready));
         rsp_done++;
      end
   end

   initial begin
      req_bus.valid     <= 1'b0;
      req_bus.cmd       <= CMD_PUSH;
      req_bus.value     <= '0;
      req_bus.tap_index <= '0;
      repeat (9) @(posedge clock);
      reset <= 1'b0;

      // With every coefficient still zero, the index of a sample request is ignored.
      send_request(CMD_PUSH, 32'h0000_0001, 5'd31);
      // A single least significant coefficient shows rounding towards minus infinity.
      send_request(CMD_COEF, 32'h0000_0001, 5'd0);
      send_request(CMD_PUSH, 32'hffff_ffff, 5'd0);
      send_request(CMD_PUSH, 32'h0000_0001, 5'd7);
      send_request(CMD_COEF, 32'h0001_0000, 5'd0);
      send_request(CMD_PUSH, 32'h7fff_ffff, 5'd0);
      send_request(CMD_PUSH, 32'h8000_0000, 5'd0);
      // Largest coefficients drive the sum past both ends of the output range.
      send_request(CMD_COEF, 32'h7fff_ffff, 5'd0);
      send_request(CMD_PUSH, 32'h7fff_ffff, 5'd0);
      send_request(CMD_PUSH, 32'h8000_0000, 5'd0);
      send_request(CMD_COEF, 32'h8000_0000, 5'd0);
      send_request(CMD_PUSH, 32'h8000_0000, 5'd0);
      send_request(CMD_COEF, 32'h8000_0000, 5'd31);
      send_request(CMD_COEF, 32'h0000_0000, 5'd0);
      send_request(CMD_PUSH, 32'h5555_5555, 5'd21);
      send_request(CMD_PUSH, 32'haaaa_aaaa, 5'd10);
      send_request(CMD_COEF, 32'hffff_0000, 5'd15);
      send_request(CMD_COEF, 32'h0001_0000, 5'd0);
      send_request(CMD_PUSH, 32'hffff_ffff, 5'd31);
      send_request(CMD_PUSH, 32'h0000_0000, 5'd0);

      for (int i = 0; i < RANDOM_ITEMS; i++) begin
         if ($urandom_range(0, 4) == 0) begin
            send_request(CMD_COEF, pick_value(), TIDX_W'($urandom_range(0, 31)));
         end else begin
            send_request(CMD_PUSH, pick_value(), TIDX_W'($urandom_range(0, 31)));
         end
      end
      req_bus.valid <= 1'b0;

      @(posedge clock);
      while (pending_count != 0) @(posedge clock);
      repeat (TAIL_CYCLES) @(posedge clock);

      $display("Run covered %0d requests: %0d samples and %0d coefficient loads.",
               sent_total, sample_total, coef_total);
      $display("Compared %0d responses, %0d of them clamped, under random gaps and stalls.",
               response_count, clamp_count);
      if (error_count == 0 && pending_count == 0) begin
         $display("TB_OK");
      end else begin
         $display("TB_ERROR");
      end
      $finish;
   end

endmodule
